/* sv/triangle_box_overlap_assert.svh */
// assertion macros for the triangle / box overlap tester
// expects aclk and aresetn to be visible where a macro is used
`ifndef TRIANGLE_BOX_OVERLAP_ASSERT_SVH
`define TRIANGLE_BOX_OVERLAP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TBO_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tbo same-cycle check failed");

// next-cycle implication, checked outside reset
`define TBO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tbo next-cycle check failed");

`endif

/* sv/tbo_pkg.sv */
// shared constants of the triangle / box overlap tester
// register indexes and the axis selection of the edge tests; no dependencies
`timescale 1ns / 1ps

package tbo_pkg;

    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_CENTRE_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTRE_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTRE_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_X   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_Y   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_Z   = 3'd5;

    localparam int AXES = 3;

    typedef logic [1:0] axis_t;

    // the two axes crossed with an edge for the test about box axis ax
    function automatic axis_t other_u(input int ax);
        axis_t r;
        r = (ax == 0) ? axis_t'(1) : axis_t'(0);
        return r;
    endfunction

    function automatic axis_t other_w(input int ax);
        axis_t r;
        r = (ax == 2) ? axis_t'(1) : axis_t'(2);
        return r;
    endfunction

endpackage

/* sv/triangle_box_overlap.sv */
// triangle / box overlap tester: 1 triangle per cycle while the result side does not stall
// stages: offsets, products, differences, edge tests, plane partial products,
// plane terms, plane sums with result register; the wide plane products set the depth
// the whole pipeline holds while the result waits, so nothing is lost or repeated
// aresetn (synchronous, active low) clears the stage valid bits and the box registers
// depends on tbo_pkg and triangle_box_overlap_assert.svh
`timescale 1ns / 1ps

`include "triangle_box_overlap_assert.svh"

module triangle_box_overlap #(
    parameter int COORD_WIDTH = 32
) (
    input  logic aclk,
    input  logic aresetn,
    // vertex0_x, vertex0_y, vertex0_z, vertex1_x .. vertex2_z, zero fill
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic s_tvalid,
    output logic s_tready,
    // overlaps, zero fill
    output logic [7:0] m_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    input  logic cfg_wr_en,
    input  logic [tbo_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COORD_WIDTH-1:0] cfg_wr_data
);
    import tbo_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int VW  = W + 1;            // offsets and edges
    localparam int PW  = 2 * VW + 1;       // edge projections, radii, normal
    localparam int MW  = W + 2;            // plane corner offsets
    localparam int LO  = W + 2;            // low split of the normal
    localparam int HW  = PW - LO;          // high split of the normal
    localparam int DW  = PW + MW + 2;      // plane distances
    localparam int NST = 7;

    typedef logic signed [VW-1:0] vco_t;
    typedef logic signed [PW-1:0] prd_t;
    typedef logic signed [MW-1:0] mco_t;
    typedef logic signed [DW-1:0] dst_t;
    typedef logic signed [LO+MW:0] plo_t;
    typedef logic signed [HW+MW-1:0] phi_t;

    // box registers
    logic signed [W-1:0] ctr_reg [AXES];
    logic [W-2:0]        half_reg [AXES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < AXES; c++) begin
                ctr_reg[c]  <= '0;
                half_reg[c] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_CENTRE_X: ctr_reg[0]  <= cfg_wr_data;
                REG_CENTRE_Y: ctr_reg[1]  <= cfg_wr_data;
                REG_CENTRE_Z: ctr_reg[2]  <= cfg_wr_data;
                REG_HALF_X:   half_reg[0] <= cfg_wr_data[W-2:0];
                REG_HALF_Y:   half_reg[1] <= cfg_wr_data[W-2:0];
                REG_HALF_Z:   half_reg[2] <= cfg_wr_data[W-2:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic adv;
    logic [NST:1] vld_reg, vld_next;

    assign adv      = !vld_reg[NST] || m_tready;
    assign s_tready = adv;
    assign vld_next = {vld_reg[NST-1:1], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: offsets from the centre and edges
    vco_t v1_reg [3][AXES], v1_next [3][AXES];
    vco_t e1_reg [3][AXES], e1_next [3][AXES];

    always_comb begin
        logic signed [W-1:0] p [3][AXES];
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < AXES; c++) begin
                p[k][c] = s_tdata[(3*k+c)*W +: W];
                v1_next[k][c] = vco_t'(p[k][c]) - vco_t'(ctr_reg[c]);
            end
        end
        for (int c = 0; c < AXES; c++) begin
            e1_next[0][c] = vco_t'(p[1][c]) - vco_t'(p[0][c]);
            e1_next[1][c] = vco_t'(p[2][c]) - vco_t'(p[1][c]);
            e1_next[2][c] = vco_t'(p[0][c]) - vco_t'(p[2][c]);
        end
    end

    // stage 2: products and box axis tests
    prd_t pa2_reg [3][AXES][3], pa2_next [3][AXES][3];
    prd_t pb2_reg [3][AXES][3], pb2_next [3][AXES][3];
    prd_t ra2_reg [3][AXES], ra2_next [3][AXES];
    prd_t rb2_reg [3][AXES], rb2_next [3][AXES];
    prd_t na2_reg [AXES], na2_next [AXES];
    prd_t nb2_reg [AXES], nb2_next [AXES];
    vco_t v02_reg [AXES], v02_next [AXES];
    logic sep2_reg, sep2_next;

    always_comb begin
        logic signed [VW:0] ae [3][AXES];
        logic signed [W-1:0] hs [AXES];
        vco_t lo, hi, hv;
        axis_t u, w;
        sep2_next = 1'b0;
        for (int c = 0; c < AXES; c++) begin
            hs[c] = $signed({1'b0, half_reg[c]});
        end
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < AXES; c++) begin
                ae[k][c] = e1_reg[k][c][VW-1] ? -($signed({e1_reg[k][c][VW-1], e1_reg[k][c]}))
                                              : $signed({e1_reg[k][c][VW-1], e1_reg[k][c]});
            end
        end
        for (int k = 0; k < 3; k++) begin
            for (int ax = 0; ax < AXES; ax++) begin
                u = other_u(ax);
                w = other_w(ax);
                for (int j = 0; j < 3; j++) begin
                    pa2_next[k][ax][j] = prd_t'(e1_reg[k][w]) * prd_t'(v1_reg[j][u]);
                    pb2_next[k][ax][j] = prd_t'(e1_reg[k][u]) * prd_t'(v1_reg[j][w]);
                end
                ra2_next[k][ax] = prd_t'(ae[k][w]) * prd_t'(hs[u]);
                rb2_next[k][ax] = prd_t'(ae[k][u]) * prd_t'(hs[w]);
            end
        end
        for (int c = 0; c < AXES; c++) begin
            na2_next[c] = prd_t'(e1_reg[0][(c+1)%3]) * prd_t'(e1_reg[1][(c+2)%3]);
            nb2_next[c] = prd_t'(e1_reg[0][(c+2)%3]) * prd_t'(e1_reg[1][(c+1)%3]);
            v02_next[c] = v1_reg[0][c];
            lo = v1_reg[0][c];
            hi = v1_reg[0][c];
            for (int k = 1; k < 3; k++) begin
                if (v1_reg[k][c] < lo) lo = v1_reg[k][c];
                if (v1_reg[k][c] > hi) hi = v1_reg[k][c];
            end
            hv = vco_t'(hs[c]);
            if (lo > hv || -hv > hi) sep2_next = 1'b1;
        end
    end

    // stage 3: projections, radii and normal
    prd_t p3_reg [3][AXES][3], p3_next [3][AXES][3];
    prd_t r3_reg [3][AXES], r3_next [3][AXES];
    prd_t n3_reg [AXES], n3_next [AXES];
    vco_t v03_reg [AXES];
    logic sep3_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int ax = 0; ax < AXES; ax++) begin
                for (int j = 0; j < 3; j++) begin
                    p3_next[k][ax][j] = pa2_reg[k][ax][j] - pb2_reg[k][ax][j];
                end
                r3_next[k][ax] = ra2_reg[k][ax] + rb2_reg[k][ax];
            end
        end
        for (int c = 0; c < AXES; c++) begin
            n3_next[c] = na2_reg[c] - nb2_reg[c];
        end
    end

    // stage 4: edge axis tests and box corners along the normal
    mco_t vmn4_reg [AXES], vmn4_next [AXES];
    mco_t vmx4_reg [AXES], vmx4_next [AXES];
    prd_t n4_reg [AXES];
    logic sep4_reg, sep4_next;

    always_comb begin
        prd_t lo, hi;
        mco_t hp, hn, v0;
        sep4_next = sep3_reg;
        for (int k = 0; k < 3; k++) begin
            for (int ax = 0; ax < AXES; ax++) begin
                lo = p3_reg[k][ax][0];
                hi = p3_reg[k][ax][0];
                for (int j = 1; j < 3; j++) begin
                    if (p3_reg[k][ax][j] < lo) lo = p3_reg[k][ax][j];
                    if (p3_reg[k][ax][j] > hi) hi = p3_reg[k][ax][j];
                end
                if (lo > r3_reg[k][ax] || -r3_reg[k][ax] > hi) sep4_next = 1'b1;
            end
        end
        for (int c = 0; c < AXES; c++) begin
            hp = $signed({3'b000, half_reg[c]});
            hn = -hp;
            v0 = mco_t'(v03_reg[c]);
            if (n3_reg[c] > 0) begin
                vmn4_next[c] = hn - v0;
                vmx4_next[c] = hp - v0;
            end else begin
                vmn4_next[c] = hp - v0;
                vmx4_next[c] = hn - v0;
            end
        end
    end

    // stage 5: plane partial products, normal split in two halves
    plo_t lmn5_reg [AXES], lmn5_next [AXES];
    plo_t lmx5_reg [AXES], lmx5_next [AXES];
    phi_t hmn5_reg [AXES], hmn5_next [AXES];
    phi_t hmx5_reg [AXES], hmx5_next [AXES];
    logic sep5_reg;

    always_comb begin
        logic signed [LO:0]   nlo;
        logic signed [HW-1:0] nhi;
        for (int c = 0; c < AXES; c++) begin
            nlo = $signed({1'b0, n4_reg[c][LO-1:0]});
            nhi = $signed(n4_reg[c][PW-1:LO]);
            lmn5_next[c] = plo_t'(nlo) * plo_t'(vmn4_reg[c]);
            lmx5_next[c] = plo_t'(nlo) * plo_t'(vmx4_reg[c]);
            hmn5_next[c] = phi_t'(nhi) * phi_t'(vmn4_reg[c]);
            hmx5_next[c] = phi_t'(nhi) * phi_t'(vmx4_reg[c]);
        end
    end

    // stage 6: plane terms per axis
    dst_t tmn6_reg [AXES], tmn6_next [AXES];
    dst_t tmx6_reg [AXES], tmx6_next [AXES];
    logic sep6_reg;

    always_comb begin
        dst_t hx, lx;
        for (int c = 0; c < AXES; c++) begin
            hx = dst_t'(hmn5_reg[c]);
            lx = dst_t'(lmn5_reg[c]);
            tmn6_next[c] = (hx <<< LO) + lx;
            hx = dst_t'(hmx5_reg[c]);
            lx = dst_t'(lmx5_reg[c]);
            tmx6_next[c] = (hx <<< LO) + lx;
        end
    end

    // stage 7: plane distances and the result
    logic ovl7_reg, ovl7_next;

    always_comb begin
        dst_t dmin, dmax;
        dmin = tmn6_reg[0] + tmn6_reg[1] + tmn6_reg[2];
        dmax = tmx6_reg[0] + tmx6_reg[1] + tmx6_reg[2];
        ovl7_next = !(sep6_reg || dmin > 0 || dmax < 0);
    end

    // payload registers follow the pipeline enable
    always_ff @(posedge aclk) begin
        if (adv) begin
            v1_reg    <= v1_next;
            e1_reg    <= e1_next;
            pa2_reg   <= pa2_next;
            pb2_reg   <= pb2_next;
            ra2_reg   <= ra2_next;
            rb2_reg   <= rb2_next;
            na2_reg   <= na2_next;
            nb2_reg   <= nb2_next;
            v02_reg   <= v02_next;
            sep2_reg  <= sep2_next;
            p3_reg    <= p3_next;
            r3_reg    <= r3_next;
            n3_reg    <= n3_next;
            v03_reg   <= v02_reg;
            sep3_reg  <= sep2_reg;
            vmn4_reg  <= vmn4_next;
            vmx4_reg  <= vmx4_next;
            n4_reg    <= n3_reg;
            sep4_reg  <= sep4_next;
            lmn5_reg  <= lmn5_next;
            lmx5_reg  <= lmx5_next;
            hmn5_reg  <= hmn5_next;
            hmx5_reg  <= hmx5_next;
            sep5_reg  <= sep4_reg;
            tmn6_reg  <= tmn6_next;
            tmx6_reg  <= tmx6_next;
            sep6_reg  <= sep5_reg;
            ovl7_reg  <= ovl7_next;
        end
    end

    assign m_tvalid = vld_reg[NST];
    assign m_tdata  = {7'b0000000, ovl7_reg};

    // a held pipeline keeps every stage
    `TBO_ASSERT_NEXT(a_stall_hold, !adv, $stable(vld_reg))
    // a new result always comes from the stage before it
    `TBO_ASSERT_IMPL(a_out_source, $rose(m_tvalid), $past(vld_reg[NST-1]))
    // an earlier separating axis forces a separated result
    `TBO_ASSERT_NEXT(a_sep_wins, adv && vld_reg[NST-1] && sep6_reg, !m_tdata[0])

endmodule

/* dv/tb_triangle_box_overlap.sv */
// self-checking testbench for triangle_box_overlap: directed rows, then random boxes and triangles
// checks each result against an exact wide-integer separating-axis predictor; needs tbo_pkg
`timescale 1ns / 1ps

module tb_triangle_box_overlap;
    import tbo_pkg::*;

    localparam int CW        = 32;
    localparam int LATENCY   = 7;
    localparam int LIMIT     = 400000;
    localparam int N_PHASES  = 13;
    localparam int PER_PHASE = 95;
    localparam logic [1:0] WANT_PREDICT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

    typedef logic signed [191:0] wide_t;
    typedef logic [8:0][CW-1:0] tri_t;
    typedef struct {
        tri_t       tv;
        logic [1:0] want;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic [9*CW-1:0] s_tdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] m_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CW-1:0] cfg_wr_data = '0;

    triangle_box_overlap #(.COORD_WIDTH(CW)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // box registers as the block should hold them (raw write data)
    logic [CW-1:0] box_ctr [3];
    logic [CW-1:0] box_half [3];
    logic overlap_q [$];
    row_t rows [$];
    int errors = 0;
    int n_checked = 0;
    int n_hits = 0;
    int cycles = 0;
    bit calm = 1'b0;

    function automatic wide_t wabs(wide_t x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic logic overlap_of(tri_t tv);
        wide_t c [3], h [3], v [3][3], e [3][3], nrm [3];
        wide_t lo, hi, rad, p, dmin, dmax;
        int u, w;
        logic sep;
        sep = 1'b0;
        for (int i = 0; i < 3; i++) begin
            c[i] = wide_t'($signed(box_ctr[i]));
            h[i] = '0;
            h[i][CW-2:0] = box_half[i][CW-2:0];
        end
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
                v[k][i] = wide_t'($signed(tv[k*3+i])) - c[i];
        for (int i = 0; i < 3; i++) begin
            e[0][i] = v[1][i] - v[0][i];
            e[1][i] = v[2][i] - v[1][i];
            e[2][i] = v[0][i] - v[2][i];
        end
        // edge cross box axis
        for (int k = 0; k < 3; k++)
            for (int ax = 0; ax < 3; ax++) begin
                u = (ax == 0) ? 1 : 0;
                w = (ax == 2) ? 1 : 2;
                for (int j = 0; j < 3; j++) begin
                    p = e[k][w] * v[j][u] - e[k][u] * v[j][w];
                    if (j == 0 || p < lo) lo = p;
                    if (j == 0 || p > hi) hi = p;
                end
                rad = wabs(e[k][w]) * h[u] + wabs(e[k][u]) * h[w];
                if (lo > rad || -rad > hi) sep = 1'b1;
            end
        // box axes
        for (int i = 0; i < 3; i++) begin
            lo = v[0][i];
            hi = v[0][i];
            for (int k = 1; k < 3; k++) begin
                if (v[k][i] < lo) lo = v[k][i];
                if (v[k][i] > hi) hi = v[k][i];
            end
            if (lo > h[i] || -h[i] > hi) sep = 1'b1;
        end
        // triangle plane
        dmin = '0;
        dmax = '0;
        for (int i = 0; i < 3; i++) begin
            u = (i + 1) % 3;
            w = (i + 2) % 3;
            nrm[i] = e[0][u] * e[1][w] - e[0][w] * e[1][u];
            if (nrm[i] > 0) begin
                dmin += nrm[i] * (-h[i] - v[0][i]);
                dmax += nrm[i] * (h[i] - v[0][i]);
            end else begin
                dmin += nrm[i] * (h[i] - v[0][i]);
                dmax += nrm[i] * (-h[i] - v[0][i]);
            end
        end
        if (dmin > 0 || dmax < 0) sep = 1'b1;
        return ~sep;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    // track writes and accepted requests, and check each returned result, as seen at the clock edge
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                box_ctr[i] = '0;
                box_half[i] = '0;
            end
        end
        if (aresetn && cfg_wr_en) begin
            case (cfg_addr)
                REG_CENTRE_X: box_ctr[0] = cfg_wr_data;
                REG_CENTRE_Y: box_ctr[1] = cfg_wr_data;
                REG_CENTRE_Z: box_ctr[2] = cfg_wr_data;
                REG_HALF_X:   box_half[0] = cfg_wr_data;
                REG_HALF_Y:   box_half[1] = cfg_wr_data;
                REG_HALF_Z:   box_half[2] = cfg_wr_data;
                default: ;
            endcase
        end
        if (aresetn && s_tvalid && s_tready)
            overlap_q.insert(overlap_q.size(), overlap_of(tri_t'(s_tdata)));
        if (aresetn && m_tvalid && m_tready) begin
            if (overlap_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                logic want;
                want = overlap_q.pop_front();
                n_checked++;
                if (m_tdata[0]) n_hits++;
                if (m_tdata[0] !== want)
                    report_mismatch($sformatf("overlaps got %b want %b", m_tdata[0], want));
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_triangle_box_overlap NOT OK");
            $finish;
        end
    end

    // result side stalls in bursts, but never in the calm last phase
    initial begin
        forever begin
            if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
                if (!calm && $urandom_range(0, 1)) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 14)) @(posedge aclk);
                end
            end
        end
    end

    // leaves the write enable high; the caller drops it after its last write
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] a, input logic [CW-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wr_data <= d;
        @(posedge aclk);
    endtask

    task automatic set_box(input logic [CW-1:0] cx, cy, cz, hx, hy, hz);
        cfg_write(REG_CENTRE_X, cx);
        cfg_write(REG_CENTRE_Y, cy);
        cfg_write(REG_CENTRE_Z, cz);
        cfg_write(REG_HALF_X, hx);
        cfg_write(REG_HALF_Y, hy);
        cfg_write(REG_HALF_Z, hz);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (overlap_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 3) @(posedge aclk);
    endtask

    task automatic send_tri(input tri_t tv);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= tv;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic dir(input logic [CW-1:0] a, b, c, d, e, f, g, h, i, input logic [1:0] want);
        row_t r;
        r.tv = {i, h, g, f, e, d, c, b, a};
        r.want = want;
        rows.insert(rows.size(), r);
    endtask

    function automatic logic [CW-1:0] near(input int axis, input logic [CW-1:0] scale);
        logic [CW-1:0] off;
        off = $urandom & ((scale << 2) - 1);
        return box_ctr[axis] + off - (scale << 1);
    endfunction

    initial begin
        tri_t tv;
        logic [CW-1:0] sc;
        int kind;
        logic [CW-1:0] one, mx, mn;
        one = 32'h0001_0000;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // box after reset is a single point at the origin
        dir(0, 0, 0, 0, 0, 0, 0, 0, 0, 2'd1);
        dir(mx, mx, mx, mx, mx, mx, mx, mx, mx, 2'd0);
        dir(mn, mn, mn, mn, mn, mn, mn, mn, mn, 2'd0);
        dir(-one, -one, 0, one, -one, 0, 0, one, 0, 2'd1);
        dir(-one, -one, one, one, -one, one, 0, one, one, 2'd0);
        dir(-one, 0, 0, one, 0, 0, one, 0, 0, WANT_PREDICT);   // segment through the point
        dir(one, 0, 0, one, 0, 0, one, 0, 0, 2'd0);
        dir(mx, 0, 0, mn, 0, 0, 0, mx, mn, WANT_PREDICT);
        dir(mn, mn, mx, mx, mx, mn, mn, mx, mx, WANT_PREDICT);
        dir(mx, mn, 0, mn, mx, 0, 0, 0, mx, WANT_PREDICT);
        dir(one, one, one, one, one, -one, -one, -one, 0, WANT_PREDICT);
        dir(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1, 1, 1, 32'hffff_ffff, 0,
            WANT_PREDICT);
        dir(0, 0, 1, 0, 0, 1, 0, 0, 1, 2'd0);
        dir(0, 0, 0, 0, 0, 0, mx, mx, mx, 2'd1);
        foreach (rows[n]) begin
            if (rows[n].want != WANT_PREDICT && overlap_of(rows[n].tv) !== rows[n].want[0])
                report_mismatch($sformatf("directed row %0d disagrees with predictor", n));
            send_tri(rows[n].tv);
        end
        s_tvalid <= 1'b0;
        wait_drained();

        for (int ph = 1; ph <= N_PHASES; ph++) begin
            calm = (ph == N_PHASES);
            case (ph)
                1: set_box(0, 0, 0, mx, mx, mx);
                2: set_box(mx, mx, mx, mx, mx, mx);
                3: set_box(mn, mn, mn, 0, 0, 0);
                4: begin
                    set_box(0, 0, 0, one, 0, one);
                    cfg_write(REG_SPARE_A, $urandom);   // unused indexes are ignored
                    cfg_write(REG_SPARE_B, $urandom);
                    cfg_wr_en <= 1'b0;
                end
                default: begin
                    sc = 32'd1 << $urandom_range(2, 28);
                    set_box($urandom & ((sc << 3) - 1), $urandom, $urandom & ((sc << 3) - 1),
                            ($urandom & (sc - 1)) | ($urandom_range(0, 1) << 31),
                            $urandom & (sc - 1), $urandom & ((sc << 1) - 1));
                end
            endcase
            sc = (box_half[0][30:0] | box_half[1][30:0] | box_half[2][30:0] | 32'h100);
            if (sc > 32'h0fff_ffff) sc = 32'h0fff_ffff;
            for (int n = 0; n < PER_PHASE; n++) begin
                kind = $urandom_range(0, 9);
                for (int k = 0; k < 9; k++) begin
                    if (kind == 0) tv[k] = $urandom;
                    else if (kind == 1) tv[k] = $urandom_range(0, 1) ? mx : mn;
                    else tv[k] = near(k % 3, sc);
                end
                if (kind == 2) tv[8:6] = tv[5:3];     // degenerate: two equal vertices
                send_tri(tv);
            end
            s_tvalid <= 1'b0;
            // hold off until every expected result is back
            wait_drained();
        end

        while (overlap_q.size() != 0) @(posedge aclk);
        repeat (LATENCY * 4) @(posedge aclk);
        $display("checked %0d triangles (%0d overlapping) over %0d box settings",
                 n_checked, n_hits, N_PHASES + 1);
        $display("errors: %0d", errors);
        if (errors == 0 && overlap_q.size() == 0) begin
            $display("tb_triangle_box_overlap OK");
        end else begin
            $display("tb_triangle_box_overlap NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/tbo_pkg.sv
sv/triangle_box_overlap.sv
dv/tb_triangle_box_overlap.sv
